@@ src/bse_pkg.sv @@
// Shared constants, codes and helpers for the bilinear edge-extrapolating sampler.
// No dependencies; imported by the frame RAM and the top level.
`timescale 1ns / 1ps

package bse_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_WIDTH  = 128;
  localparam int unsigned DEF_MAX_HEIGHT = 128;
  localparam int unsigned DEF_FRAC_BITS  = 8;

  // Fixed field widths
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned SIZE_REG_W  = 8;
  localparam int unsigned VALUE_W     = 12;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned WCOORD_W    = 7;
  localparam int unsigned CFG_IDX_W   = 1;

  // Opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // Channel codes
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  function automatic logic [7:0] pick_channel(logic [PIXEL_W-1:0] px, logic [1:0] ch);
    logic [7:0] b;
    case (ch)
      CH_BLUE:  b = px[7:0];
      CH_GREEN: b = px[15:8];
      CH_RED:   b = px[23:16];
      CH_ALPHA: b = px[31:24];
      default:  b = px[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ src/bse_frame_ram.sv @@
// Single-port frame store, one write or one read per cycle, registered read data.
// Depends on bse_pkg for the pixel width.
`timescale 1ns / 1ps

module bse_frame_ram #(
  parameter int unsigned DEPTH  = 16384,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           addr_i,
  input  logic [bse_pkg::PIXEL_W-1:0] wdata_i,
  output logic [bse_pkg::PIXEL_W-1:0] rdata_o
);
  import bse_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

@@ src/bilinear_sampler_edge_extrapolate.sv @@
// Top level of the bilinear sampler with linear edge extrapolation.
// Depends on bse_pkg and bse_frame_ram.
`timescale 1ns / 1ps

// Command-style block. An item is taken at a clock edge where start_i is high and busy_o
// is low. A pixel write (opcode 0) goes straight into the single-port frame store in the
// accept cycle and is finished at once; the next item may follow in the next cycle. A
// sample request (opcode 1) holds busy_o from S_CALC through S_DONE, taking no new item:
// the four neighbour pixels come through the one memory port, one read per cycle, and the
// four weighted terms are summed by one shared multiply-accumulate unit, one term per
// cycle. A request whose position falls outside the image holds busy_o for one cycle
// only. Every result shows on sample_value_o / range_error_o for exactly one cycle with
// result_valid_o high; the receiver cannot stall, so take each beat as it comes. The
// frame store has no reset: read only pixels already written. Size registers are written
// over the cfg channel (always ready); the user must do so only while the block is idle,
// not enforced by the block; a width or height below 2 acts as 2, one above MAX as MAX.
module bilinear_sampler_edge_extrapolate #(
  parameter int unsigned MAX_WIDTH  = bse_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bse_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned FRAC_BITS  = bse_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [bse_pkg::WCOORD_W-1:0]        write_col_i,
  input  logic [bse_pkg::WCOORD_W-1:0]        write_row_i,
  input  logic [bse_pkg::PIXEL_W-1:0]         pixel_word_i,
  input  logic [bse_pkg::POS_W-1:0]           sample_x_i,
  input  logic [bse_pkg::POS_W-1:0]           sample_y_i,
  input  logic [1:0]                          channel_i,
  // result strobe
  output logic                                result_valid_o,
  output logic signed [bse_pkg::VALUE_W-1:0]  sample_value_o,
  output logic                                range_error_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bse_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bse_pkg::SIZE_REG_W-1:0]      cfg_data_i
);
  import bse_pkg::*;

  localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned SZ_W    = $clog2(MAX_DIM + 1);
  localparam int unsigned IX_W    = POS_W + 1 - FRAC_BITS;   // ceil of a position
  localparam int unsigned CW      = (IX_W > SZ_W) ? IX_W : SZ_W;
  localparam int unsigned ONE     = 1 << FRAC_BITS;
  localparam int unsigned FW_W    = FRAC_BITS + 1;           // one weight factor, 0..ONE
  localparam int unsigned WT_W    = 2 * FRAC_BITS + 1;       // product of two factors
  localparam int unsigned PROD_W  = WT_W + 1 + VALUE_W;
  localparam int unsigned ACC_W   = PROD_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_ADDR, S_READ, S_WAIT, S_COMB, S_MAC, S_DONE
  } state_e;

  state_e state_q;
  logic [1:0] cnt_q;
  logic       result_valid_q, range_error_q;
  logic signed [VALUE_W-1:0] sample_value_q;
  logic [SIZE_REG_W-1:0] image_width_q, image_height_q;

  // per-sample working registers
  logic [POS_W-1:0]  sx_q, sy_q;
  logic [1:0]        ch_q;
  logic [SZ_W-1:0]   w_q, h_q;
  logic [CW-1:0]     ix_q, iy_q;
  logic [FW_W-1:0]   fw_q, gw_q;
  logic              atright_q, attop_q;
  logic [COL_W-1:0]  col0_q, col1_q;
  logic [ADDR_W-1:0] base0_q, base1_q;
  logic [WT_W-1:0]   wt_q  [4];
  logic [7:0]        pix_q [4];
  logic signed [VALUE_W-1:0] val_q [4];
  logic signed [ACC_W-1:0]   acc_q;

  logic accept;
  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Effective image size: clamp the registers into 2..MAX
  // ---------------------------------------------------------------------------
  logic [SZ_W-1:0] w_eff, h_eff;
  always_comb begin
    if (image_width_q < SIZE_REG_W'(2)) begin
      w_eff = SZ_W'(2);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_eff = SZ_W'(MAX_WIDTH);
    end else begin
      w_eff = SZ_W'(image_width_q);
    end
    if (image_height_q < SIZE_REG_W'(2)) begin
      h_eff = SZ_W'(2);
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      h_eff = SZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = SZ_W'(image_height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Position decode: ix = ceil(x), weight fw = x - (ix-1), in (0, ONE]
  // ---------------------------------------------------------------------------
  logic [POS_W:0]  sum_x, sum_y;
  logic [CW-1:0]   ix_c, iy_c;
  logic [FW_W-1:0] fw_c, gw_c;
  logic            err_c;

  assign sum_x = {1'b0, sx_q} + (POS_W + 1)'(ONE - 1);
  assign sum_y = {1'b0, sy_q} + (POS_W + 1)'(ONE - 1);
  assign ix_c  = CW'(sum_x[POS_W:FRAC_BITS]);
  assign iy_c  = CW'(sum_y[POS_W:FRAC_BITS]);
  assign fw_c  = (sx_q[FRAC_BITS-1:0] == '0) ? FW_W'(ONE) : {1'b0, sx_q[FRAC_BITS-1:0]};
  assign gw_c  = (sy_q[FRAC_BITS-1:0] == '0) ? FW_W'(ONE) : {1'b0, sy_q[FRAC_BITS-1:0]};
  assign err_c = (ix_c == '0) || (iy_c == '0) || (ix_c > CW'(w_q)) || (iy_c > CW'(h_q));

  // ---------------------------------------------------------------------------
  // Neighbour addresses: the second column/row steps inward at the far edge
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col0_c, col1_c, row0_c, row1_c;
  assign col0_c = ix_q - CW'(1);
  assign col1_c = atright_q ? (ix_q - CW'(2)) : ix_q;
  assign row0_c = iy_q - CW'(1);
  assign row1_c = attop_q ? (iy_q - CW'(2)) : iy_q;

  // ---------------------------------------------------------------------------
  // Frame store port: writes while idle, neighbour reads while sampling
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr, wr_addr, rd_addr;
  logic [PIXEL_W-1:0] ram_rdata;
  logic              wr_in_store;

  assign wr_in_store = (32'(write_col_i) < MAX_WIDTH) && (32'(write_row_i) < MAX_HEIGHT);
  assign wr_addr     = ADDR_W'(32'(write_row_i) * MAX_WIDTH + 32'(write_col_i));
  assign rd_addr     = (cnt_q[1] ? base1_q : base0_q)
                     + ADDR_W'(cnt_q[0] ? col1_q : col0_q);
  assign ram_we      = accept && (opcode_i == OP_WRITE) && wr_in_store;
  assign ram_addr    = (state_q == S_READ) ? rd_addr : wr_addr;

  bse_frame_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pixel_word_i),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Weights: term k uses the x factor picked by bit 0 and the y factor by bit 1
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0]   fx_sel, gy_sel;
  logic [2*FW_W-1:0] wt_prod;
  assign fx_sel  = cnt_q[0] ? fw_q : (FW_W'(ONE) - fw_q);
  assign gy_sel  = cnt_q[1] ? gw_q : (FW_W'(ONE) - gw_q);
  assign wt_prod = fx_sel * gy_sel;

  // ---------------------------------------------------------------------------
  // Edge extrapolation of the four taps
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] p0, p1, p2, p3, va, vb, vc, vd, rc;
  always_comb begin
    p0 = $signed({{(VALUE_W-8){1'b0}}, pix_q[0]});
    p1 = $signed({{(VALUE_W-8){1'b0}}, pix_q[1]});
    p2 = $signed({{(VALUE_W-8){1'b0}}, pix_q[2]});
    p3 = $signed({{(VALUE_W-8){1'b0}}, pix_q[3]});
    va = p0;
    vb = atright_q ? ((p0 <<< 1) - p1) : p1;
    rc = atright_q ? ((p2 <<< 1) - p3) : p3;
    vc = attop_q   ? ((va <<< 1) - p2) : p2;
    vd = attop_q   ? ((vb <<< 1) - rc) : rc;
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-accumulate and truncation toward zero
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] mac_prod;
  logic signed [ACC_W-1:0]  acc_d;
  logic [ACC_W-1:0]         acc_mag, acc_shr, res_full;

  assign mac_prod = $signed({1'b0, wt_q[cnt_q]}) * val_q[cnt_q];
  assign acc_d    = acc_q + ACC_W'(mac_prod);
  assign acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign acc_shr  = acc_mag >> (2 * FRAC_BITS);
  assign res_full = acc_q[ACC_W-1] ? (~acc_shr + ACC_W'(1)) : acc_shr;

  // ---------------------------------------------------------------------------
  // Sequencer, size registers and result beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cnt_q          <= '0;
      result_valid_q <= 1'b0;
      range_error_q  <= 1'b0;
      sample_value_q <= '0;
      image_width_q  <= SIZE_REG_W'(128);
      image_height_q <= SIZE_REG_W'(128);
    end else begin
      result_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (opcode_i == OP_SAMPLE)) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          if (err_c) begin
            // outside the image: answer at once with a zero value
            result_valid_q <= 1'b1;
            range_error_q  <= 1'b1;
            sample_value_q <= '0;
            state_q        <= S_IDLE;
          end else begin
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          cnt_q   <= '0;
          state_q <= S_READ;
        end
        S_READ: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          state_q <= S_COMB;
        end
        S_COMB: begin
          cnt_q   <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          result_valid_q <= 1'b1;
          range_error_q  <= 1'b0;
          sample_value_q <= $signed(res_full[VALUE_W-1:0]);
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: payload only, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sx_q <= sample_x_i;
          sy_q <= sample_y_i;
          ch_q <= channel_i;
          w_q  <= w_eff;
          h_q  <= h_eff;
        end
      end
      S_CALC: begin
        ix_q      <= ix_c;
        iy_q      <= iy_c;
        fw_q      <= fw_c;
        gw_q      <= gw_c;
        atright_q <= (ix_c == CW'(w_q));
        attop_q   <= (iy_c == CW'(h_q));
      end
      S_ADDR: begin
        col0_q  <= col0_c[COL_W-1:0];
        col1_q  <= col1_c[COL_W-1:0];
        base0_q <= ADDR_W'(32'(row0_c[ROW_W-1:0]) * MAX_WIDTH);
        base1_q <= ADDR_W'(32'(row1_c[ROW_W-1:0]) * MAX_WIDTH);
      end
      S_READ: begin
        wt_q[cnt_q] <= wt_prod[WT_W-1:0];
        // read data arrives in the cycle after its address
        if (cnt_q != 2'd0) begin
          pix_q[cnt_q - 2'd1] <= pick_channel(ram_rdata, ch_q);
        end
      end
      S_WAIT: begin
        pix_q[3] <= pick_channel(ram_rdata, ch_q);
      end
      S_COMB: begin
        val_q[0] <= va;
        val_q[1] <= vb;
        val_q[2] <= vc;
        val_q[3] <= vd;
        acc_q    <= '0;
      end
      S_MAC: begin
        acc_q <= acc_d;
      end
      default: ;
    endcase
  end

  assign result_valid_o = result_valid_q;
  assign sample_value_o = sample_value_q;
  assign range_error_o  = range_error_q;

endmodule
